[design/fit_based_block_allocator_assert.svh]
// assertion macros shared by the allocator modules
// expects clk and rst_n in scope at the point of use
`ifndef FIT_BASED_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIT_BASED_BLOCK_ALLOCATOR_ASSERT_SVH

// property must hold at every clock edge out of reset
`define FBBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// expression must never be true out of reset
`define FBBA_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

[design/fbba_pkg.sv]
// shared constants, codes and control types of the fit based block allocator
// no dependencies
package fbba_pkg;

  localparam int BLOCKS     = 16;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_W      = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int CNT_W      = $clog2(BLOCKS + 1);
  localparam int BLK_W      = 4;
  localparam int SZF_W      = 16;
  localparam int BIU_W      = 5;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [MODE_W-1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_NEXT  = 2'd2
  } fit_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIT_MODE      = 8'd0,
    CFG_BLOCKS_IN_USE = 8'd1
  } cfg_reg_t;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_ALLOC = 1'b1
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOC = 2'd0,
    ST_NOFIT = 2'd1,
    ST_LOAD  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } ctl_state_t;

  typedef struct packed {
    logic capture;
    logic scan_step;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_is_load;
    logic scan_done;
    logic out_free;
  } ctl_sts_t;

endpackage

[design/fbba_in_if.sv]
// request channel of the allocator: valid, ready and the request fields
// depends on fbba_pkg
interface fbba_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [fbba_pkg::BLK_W-1:0]  block_index;
  logic [fbba_pkg::SZF_W-1:0]  size_value;

  modport source (output valid, action, block_index, size_value, input ready);
  modport sink (input valid, action, block_index, size_value, output ready);
endinterface

[design/fbba_out_if.sv]
// result channel of the allocator: valid, ready and the result fields
// depends on fbba_pkg
interface fbba_out_if;
  logic                          valid;
  logic                          ready;
  logic [fbba_pkg::STATUS_W-1:0] status;
  logic [fbba_pkg::BLK_W-1:0]    chosen_block;
  logic [fbba_pkg::SZF_W-1:0]    remaining_size;

  modport source (output valid, status, chosen_block, remaining_size, input ready);
  modport sink (input valid, status, chosen_block, remaining_size, output ready);
endinterface

[design/fbba_cfg_if.sv]
// configuration write channel: valid, ready, register index and write data
// depends on fbba_pkg
interface fbba_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fbba_pkg::CFG_IDX_W-1:0]  index;
  logic [fbba_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/fit_based_block_allocator.sv]
// top level of the fit based block allocator: controller plus datapath
// depends on fbba_pkg, fbba_in_if, fbba_out_if, fbba_cfg_if, fbba_ctrl, fbba_dpath

// Keeps the free size of up to 16 blocks and serves one request at a time.
// A load request (action 0) writes one block size and answers status 2 with
// that index and the stored size. It goes from the accept state straight to
// the finish state, with no scan. An allocate request (action 1) scans the
// table one entry per clock under the fit mode register (0 first fit, 1 best
// fit, 2 next fit, 3 always fails), shrinks the chosen block and answers
// status 0 with its index and what is left, or status 1 with zeros when
// nothing fits. An allocation passes the accept state, the scan state over
// the searched entries (blocks_in_use clamped to 16; the scan ends on its
// first step when nothing can be searched) and the finish state, with a
// single table read per scan step. Best fit walks every searched entry
// unless it fails at once on a request size of zero; first and next fit
// stop at the first hit. The result waits in an output register; a new
// request is accepted once the previous one has finished, even while its
// result is still unread, but its own finish step then waits until that
// result is taken. Config writes (register 0 fit_mode, register 1
// blocks_in_use) are always accepted and must only be issued while no
// request is in flight. The table resets to all zero with no clearing pass.
module fit_based_block_allocator (
  input logic        clk,
  input logic        rst_n,
  fbba_in_if.sink    in_ch,
  fbba_out_if.source out_ch,
  fbba_cfg_if.sink   cfg_ch
);
  import fbba_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // config writes never stall
  assign cfg_ch.ready = 1'b1;

  // sequencer: idle, scan, finish
  fbba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table, scan registers and result register
  fbba_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_action          (in_ch.action),
    .in_block_index     (in_ch.block_index),
    .in_size_value      (in_ch.size_value),
    .cfg_wr             (cfg_ch.valid),
    .cfg_index          (cfg_ch.index),
    .cfg_data           (cfg_ch.data),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_status         (out_ch.status),
    .out_chosen_block   (out_ch.chosen_block),
    .out_remaining_size (out_ch.remaining_size)
  );

endmodule

[design/fbba_ctrl.sv]
// allocator controller: idle, table scan and finish sequencing
// depends on fbba_pkg and fit_based_block_allocator_assert.svh
`include "fit_based_block_allocator_assert.svh"

module fbba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fbba_pkg::ctl_sts_t sts,
  output fbba_pkg::ctl_cmd_t cmd
);
  import fbba_pkg::*;

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.in_is_load ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      S_FINISH: begin
        cmd.finish = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  `FBBA_ASSERT(a_finish_needs_slot, cmd.finish |-> sts.out_free, "finish without free output slot")
  `FBBA_ASSERT(a_load_skips_scan, (cmd.capture && sts.in_is_load) |=> (state_r == S_FINISH), "load request did not go straight to finish")
  `FBBA_ASSERT(a_scan_exit, (state_r == S_SCAN && sts.scan_done) |=> (state_r == S_FINISH), "scan end did not reach finish")

endmodule

[design/fbba_dpath.sv]
// allocator datapath: config registers, free size table, scan and result register
// depends on fbba_pkg and fit_based_block_allocator_assert.svh
`include "fit_based_block_allocator_assert.svh"

module fbba_dpath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  fbba_pkg::ctl_cmd_t              cmd,
  output fbba_pkg::ctl_sts_t              sts,
  input  logic                            in_action,
  input  logic [fbba_pkg::BLK_W-1:0]      in_block_index,
  input  logic [fbba_pkg::SZF_W-1:0]      in_size_value,
  input  logic                            cfg_wr,
  input  logic [fbba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbba_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [fbba_pkg::STATUS_W-1:0]   out_status,
  output logic [fbba_pkg::BLK_W-1:0]      out_chosen_block,
  output logic [fbba_pkg::SZF_W-1:0]      out_remaining_size
);
  import fbba_pkg::*;

  logic [MODE_W-1:0]    fit_mode_r;
  logic [BIU_W-1:0]     biu_r;
  logic [SIZE_BITS-1:0] table_r [BLOCKS];
  logic [IDX_W-1:0]     ptr_r;
  logic                 load_r;
  logic [BLK_W-1:0]     blk_r;
  logic [SIZE_BITS-1:0] req_r;
  logic [IDX_W-1:0]     scan_idx_r;
  logic [CNT_W-1:0]     scan_cnt_r;
  logic                 found_r;
  logic [IDX_W-1:0]     pick_r;
  logic [SIZE_BITS-1:0] left_r;
  logic                 out_valid_r;
  status_t              out_status_r;
  logic [BLK_W-1:0]     out_blk_r;
  logic [SZF_W-1:0]     out_rem_r;

  logic [CNT_W-1:0]     n_eff;
  logic [IDX_W-1:0]     start_idx;
  logic [SIZE_BITS-1:0] entry;
  logic [SIZE_BITS-1:0] diff;
  logic                 hit;
  logic                 abort;
  logic                 take;
  logic                 last;
  logic                 wrap;
  logic                 load_in_range;

  // searched entry count, clamped to the table depth
  always_comb begin
    if (int'(biu_r) > BLOCKS) begin
      n_eff = CNT_W'(BLOCKS);
    end else begin
      n_eff = CNT_W'(biu_r);
    end
  end

  // next fit resumes at the pointer unless it lies past the searched range
  always_comb begin
    start_idx = '0;
    if (fit_mode_r == FIT_NEXT && CNT_W'(ptr_r) < n_eff) begin
      start_idx = ptr_r;
    end
  end

  assign entry = table_r[scan_idx_r];
  assign diff  = entry - req_r;

  always_comb begin
    case (fit_mode_r) inside
      FIT_FIRST, FIT_BEST: hit = (entry != '0) && (entry >= req_r);
      FIT_NEXT:            hit = (entry >= req_r);
      default:             hit = 1'b0;
    endcase
  end

  assign abort = (n_eff == '0) || (fit_mode_r == FIT_BEST && req_r == '0) ||
                 !(fit_mode_r == FIT_FIRST || fit_mode_r == FIT_BEST ||
                   fit_mode_r == FIT_NEXT);
  // best fit keeps the later block on a tie
  assign take  = hit && !abort &&
                 (fit_mode_r != FIT_BEST || !found_r || diff <= left_r);
  assign last  = (CNT_W'(scan_cnt_r + CNT_W'(1)) == n_eff);
  assign wrap  = (CNT_W'(CNT_W'(scan_idx_r) + CNT_W'(1)) == n_eff);
  assign load_in_range = (int'(blk_r) < BLOCKS);

  always_comb begin
    sts.in_is_load = (in_action == ACT_LOAD);
    sts.scan_done  = abort || last || (hit && fit_mode_r != FIT_BEST);
    sts.out_free   = !out_valid_r || out_ready;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r <= FIT_FIRST;
      biu_r      <= BIU_W'(16);
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_FIT_MODE:      fit_mode_r <= cfg_data[MODE_W-1:0];
        CFG_BLOCKS_IN_USE: biu_r      <= cfg_data[BIU_W-1:0];
        default:           fit_mode_r <= fit_mode_r;
      endcase
    end
  end

  // request capture and scan bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.capture) begin
      found_r <= 1'b0;
    end else if (cmd.scan_step && take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      load_r     <= (in_action == ACT_LOAD);
      blk_r      <= in_block_index;
      req_r      <= SIZE_BITS'(in_size_value);
      scan_idx_r <= start_idx;
      scan_cnt_r <= '0;
    end else if (cmd.scan_step) begin
      scan_idx_r <= wrap ? '0 : IDX_W'(CNT_W'(scan_idx_r) + CNT_W'(1));
      scan_cnt_r <= CNT_W'(scan_cnt_r + CNT_W'(1));
    end
    if (cmd.scan_step && take) begin
      pick_r <= scan_idx_r;
      left_r <= diff;
    end
  end

  // free size table and next fit pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BLOCKS; i++) begin
        table_r[i] <= '0;
      end
      ptr_r <= '0;
    end else if (cmd.finish) begin
      if (load_r) begin
        if (load_in_range) begin
          table_r[IDX_W'(blk_r)] <= req_r;
        end
      end else if (found_r) begin
        table_r[pick_r] <= left_r;
        if (fit_mode_r == FIT_NEXT) begin
          ptr_r <= pick_r;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (load_r) begin
        out_status_r <= ST_LOAD;
        out_blk_r    <= blk_r;
        out_rem_r    <= load_in_range ? SZF_W'(req_r) : '0;
      end else if (found_r) begin
        out_status_r <= ST_ALLOC;
        out_blk_r    <= BLK_W'(pick_r);
        out_rem_r    <= SZF_W'(left_r);
      end else begin
        out_status_r <= ST_NOFIT;
        out_blk_r    <= '0;
        out_rem_r    <= '0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_chosen_block   = out_blk_r;
  assign out_remaining_size = out_rem_r;

  `FBBA_NEVER(a_scan_in_range, cmd.scan_step && !abort && scan_cnt_r >= n_eff, "scan ran past searched entries")
  `FBBA_ASSERT(a_result_on_finish, cmd.finish |=> out_valid_r, "finish did not post a result")

endmodule
